// File: rtl/core/woa_waypoint_update_and_path_length_macros.svh
// assertion macros for the waypoint update block
`ifndef WOA_WAYPOINT_UPDATE_AND_PATH_LENGTH_MACROS_SVH
`define WOA_WAYPOINT_UPDATE_AND_PATH_LENGTH_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define WOA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define WOA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/woa_pkg.sv
// shared types and constants for the waypoint update block
`default_nettype none

package woa_pkg;

  localparam int CoordWidth  = 20;
  localparam int PackWidth   = 2 * CoordWidth;
  localparam int GainWidth   = 16;
  localparam int GainCWidth  = 13;
  localparam int GainFrac    = 12;
  localparam int LenWidth    = 32;
  localparam int MulWidth    = (CoordWidth + 2 > GainWidth + 1) ? CoordWidth + 2 : GainWidth + 1;
  localparam int ProdWidth   = 2 * MulWidth;
  localparam int DiffWidth   = CoordWidth + 1;
  localparam int SqWidth     = 2 * CoordWidth;
  localparam int RootWidth   = CoordWidth + 1;
  localparam int RadWidth    = 2 * RootWidth;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = PackWidth;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MODE   = 3'd0,
    REG_GAIN_A = 3'd1,
    REG_GAIN_C = 3'd2,
    REG_SPIRAL = 3'd3,
    REG_LOW    = 3'd4,
    REG_HIGH   = 3'd5,
    REG_START  = 3'd6,
    REG_GOAL   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                         mode_spiral;
    logic signed [GainWidth-1:0]  gain_a;
    logic        [GainCWidth-1:0] gain_c;
    logic signed [GainWidth-1:0]  spiral_coef;
    logic        [PackWidth-1:0]  bound_low;
    logic        [PackWidth-1:0]  bound_high;
    logic        [PackWidth-1:0]  start_point;
    logic        [PackWidth-1:0]  goal_point;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] cur_x;
    logic signed [CoordWidth-1:0] cur_y;
    logic signed [CoordWidth-1:0] lead_x;
    logic signed [CoordWidth-1:0] lead_y;
    logic                         last_point;
  } in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] new_x;
    logic signed [CoordWidth-1:0] new_y;
    logic                         was_clamped;
    logic        [LenWidth-1:0]   path_length;
    logic                         length_final;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/core/woa_cfg.sv
// configuration register file
`default_nettype none

module woa_cfg (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [woa_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  wire  [woa_pkg::CfgDataWidth-1:0]    cfg_data,
  output woa_pkg::cfg_t                       cfg
);
  import woa_pkg::*;

  // writes must land only while idle; the user must see to it, the block does not enforce it, so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_spiral <= 1'b0;
      cfg.gain_a      <= '0;
      cfg.gain_c      <= GainCWidth'(4096);
      cfg.spiral_coef <= GainWidth'(4096);
      cfg.bound_low   <= '0;
      cfg.bound_high  <= '0;
      cfg.start_point <= '0;
      cfg.goal_point  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   cfg.mode_spiral <= cfg_data[0];
        REG_GAIN_A: cfg.gain_a      <= cfg_data[GainWidth-1:0];
        REG_GAIN_C: cfg.gain_c      <= cfg_data[GainCWidth-1:0];
        REG_SPIRAL: cfg.spiral_coef <= cfg_data[GainWidth-1:0];
        REG_LOW:    cfg.bound_low   <= cfg_data[PackWidth-1:0];
        REG_HIGH:   cfg.bound_high  <= cfg_data[PackWidth-1:0];
        REG_START:  cfg.start_point <= cfg_data[PackWidth-1:0];
        REG_GOAL:   cfg.goal_point  <= cfg_data[PackWidth-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/woa_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module woa_mul (
  input  wire                                       clk,
  input  wire  signed [woa_pkg::MulWidth-1:0]       op_a,
  input  wire  signed [woa_pkg::MulWidth-1:0]       op_b,
  output logic signed [woa_pkg::ProdWidth-1:0]      prod
);
  import woa_pkg::*;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

`default_nettype wire

// File: rtl/core/woa_isqrt.sv
// bit-serial integer square root, one result bit per cycle
`default_nettype none

module woa_isqrt (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire  [woa_pkg::RadWidth-1:0]        radicand,
  output logic                                done,
  output logic [woa_pkg::RootWidth-1:0]       root
);
  import woa_pkg::*;

  localparam int RemWidth = RootWidth + 2;
  localparam int CntWidth = $clog2(RootWidth + 1);

  logic [RadWidth-1:0] rad;
  logic [RemWidth-1:0] rem;
  logic [CntWidth-1:0] cnt;
  logic [RemWidth-1:0] rem_sh;
  logic [RemWidth-1:0] trial;
  logic                fits;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem[RemWidth-3:0], rad[RadWidth-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= CntWidth'(RootWidth);
      done <= 1'b0;
    end else if (cnt != '0) begin
      rad  <= {rad[RadWidth-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[RootWidth-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == CntWidth'(1)) begin
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/woa_waypoint_update_and_path_length.sv
// waypoint update (circular or spiral), bound clamp and running path length
// one item at a time: a new item is taken only once the last has reached the output
// register, pacing set by the bit-serial root and the one shared multiplier; an item
// marked last_point also measures the segment to the goal
// a result sits in the output register while the next item is taken
// reset (rst, synchronous): registers to defaults, path length 0, next item starts a path
`default_nettype none
`include "woa_waypoint_update_and_path_length_macros.svh"

module woa_waypoint_update_and_path_length (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  woa_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output woa_pkg::out_t                     out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [woa_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  wire  [woa_pkg::CfgDataWidth-1:0]  cfg_data
);
  import woa_pkg::*;

  localparam int CW = CoordWidth;
  localparam int PW = ProdWidth;
  localparam logic signed [PW-1:0] RoundHalf = PW'(1) << (GainFrac - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_C,
    S_DIFF,
    S_MUL_K,
    S_UPD,
    S_SEG_DX,
    S_SEG_SQX,
    S_SEG_SQY,
    S_SEG_SUM,
    S_SEG_ROOT,
    S_FINISH
  } state_t;

  // sign-extend a coordinate to product width
  function automatic logic signed [PW-1:0] sx(input logic signed [CW-1:0] v);
    sx = {{(PW-CW){v[CW-1]}}, v};
  endfunction

  // gain product back to coordinate format, nearest with ties upward
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
    rnd = (p + RoundHalf) >>> GainFrac;
  endfunction

  function automatic logic [PW-1:0] mag(input logic signed [PW-1:0] v);
    mag = v[PW-1] ? -v : v;
  endfunction

  cfg_t cfg;

  state_t                       state;
  in_t                          item;
  logic                         sel;        // 0 while working on x, 1 on y
  logic                         goal_pass;  // second segment, to the goal
  logic [DiffWidth-1:0]         dreg;
  logic signed [CW-1:0]         nx, ny;
  logic signed [CW-1:0]         ax, ay;     // far end of the current segment
  logic                         clamped;
  logic [LenWidth-1:0]          acc;
  logic [SqWidth-1:0]           sum;

  // state that outlives an item
  logic signed [CW-1:0]         prev_x, prev_y;
  logic [LenWidth-1:0]          length_acc;
  logic                         at_path_start;

  // shared multiplier
  logic signed [MulWidth-1:0]   op_a, op_b;
  logic signed [PW-1:0]         prod;

  // root unit
  logic                         sq_start;
  logic [RadWidth-1:0]          sq_radicand;
  logic                         sq_done;
  logic [RootWidth-1:0]         sq_root;

  // datapath
  logic signed [CW-1:0]         cur_sel, lead_sel;
  logic signed [PW-1:0]         lo_sel, hi_sel;
  logic signed [PW-1:0]         diff_val, upd_val;
  logic [LenWidth:0]            acc_sum;
  logic                         out_load;

  woa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  woa_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  woa_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign in_ready = (state == S_IDLE);
  assign out_load = !out_valid || out_ready;

  assign cur_sel  = sel ? item.cur_y  : item.cur_x;
  assign lead_sel = sel ? item.lead_y : item.lead_x;
  assign lo_sel   = sel ? sx($signed(cfg.bound_low[PackWidth-1:CW]))
                        : sx($signed(cfg.bound_low[CW-1:0]));
  assign hi_sel   = sel ? sx($signed(cfg.bound_high[PackWidth-1:CW]))
                        : sx($signed(cfg.bound_high[CW-1:0]));

  // circular: round(C*lead) - cur, spiral: lead - cur; its magnitude goes into dreg
  assign diff_val = cfg.mode_spiral ? sx(lead_sel) - sx(cur_sel)
                                    : rnd(prod) - sx(cur_sel);
  // circular: lead - round(A*d), spiral: lead + round(k*d)
  assign upd_val  = cfg.mode_spiral ? sx(lead_sel) + rnd(prod)
                                    : sx(lead_sel) - rnd(prod);

  assign sq_start    = (state == S_SEG_SUM);
  assign sq_radicand = RadWidth'(sum) + RadWidth'(prod[SqWidth-1:0]);
  assign acc_sum     = {1'b0, acc} + (LenWidth+1)'(sq_root);

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_MUL_C: begin
        op_a = MulWidth'(cfg.gain_c);
        op_b = {{(MulWidth-CW){lead_sel[CW-1]}}, lead_sel};
      end
      S_MUL_K: begin
        op_a = cfg.mode_spiral ?
               {{(MulWidth-GainWidth){cfg.spiral_coef[GainWidth-1]}}, cfg.spiral_coef} :
               {{(MulWidth-GainWidth){cfg.gain_a[GainWidth-1]}}, cfg.gain_a};
        op_b = MulWidth'(dreg);
      end
      S_SEG_SQX, S_SEG_SQY: begin
        op_a = MulWidth'(dreg);
        op_b = MulWidth'(dreg);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      prev_x        <= '0;
      prev_y        <= '0;
      length_acc    <= '0;
      at_path_start <= 1'b1;
    end else begin
      // the finish state reloads the output itself
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item      <= in_data;
            sel       <= 1'b0;
            goal_pass <= 1'b0;
            clamped   <= 1'b0;
            // first segment of a path starts at the fixed start point
            if (at_path_start) begin
              ax  <= $signed(cfg.start_point[CW-1:0]);
              ay  <= $signed(cfg.start_point[PackWidth-1:CW]);
              acc <= '0;
            end else begin
              ax  <= prev_x;
              ay  <= prev_y;
              acc <= length_acc;
            end
            state <= cfg.mode_spiral ? S_DIFF : S_MUL_C;
          end
        end
        S_MUL_C: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          dreg  <= DiffWidth'(mag(diff_val));
          state <= S_MUL_K;
        end
        S_MUL_K: begin
          state <= S_UPD;
        end
        S_UPD: begin
          // clamp; with inverted bounds anything not below the minimum goes to the maximum
          if (upd_val < lo_sel) begin
            clamped <= 1'b1;
            if (sel) ny <= CW'(lo_sel);
            else     nx <= CW'(lo_sel);
          end else if (upd_val > hi_sel) begin
            clamped <= 1'b1;
            if (sel) ny <= CW'(hi_sel);
            else     nx <= CW'(hi_sel);
          end else begin
            if (sel) ny <= CW'(upd_val);
            else     nx <= CW'(upd_val);
          end
          if (!sel) begin
            sel   <= 1'b1;
            state <= cfg.mode_spiral ? S_DIFF : S_MUL_C;
          end else begin
            state <= S_SEG_DX;
          end
        end
        S_SEG_DX: begin
          dreg  <= DiffWidth'(mag(sx(ax) - sx(nx)));
          state <= S_SEG_SQX;
        end
        S_SEG_SQX: begin
          dreg  <= DiffWidth'(mag(sx(ay) - sx(ny)));
          state <= S_SEG_SQY;
        end
        S_SEG_SQY: begin
          sum   <= prod[SqWidth-1:0];
          state <= S_SEG_SUM;
        end
        S_SEG_SUM: begin
          state <= S_SEG_ROOT;
        end
        S_SEG_ROOT: begin
          if (sq_done) begin
            // saturating add of the segment length
            acc <= acc_sum[LenWidth] ? '1 : acc_sum[LenWidth-1:0];
            if (item.last_point && !goal_pass) begin
              goal_pass <= 1'b1;
              ax        <= $signed(cfg.goal_point[CW-1:0]);
              ay        <= $signed(cfg.goal_point[PackWidth-1:CW]);
              state     <= S_SEG_DX;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          // wait for the output register to be free
          if (out_load) begin
            out_valid             <= 1'b1;
            out_data.new_x        <= nx;
            out_data.new_y        <= ny;
            out_data.was_clamped  <= clamped;
            out_data.path_length  <= acc;
            out_data.length_final <= item.last_point;
            prev_x                <= nx;
            prev_y                <= ny;
            if (item.last_point) begin
              length_acc    <= '0;
              at_path_start <= 1'b1;
            end else begin
              length_acc    <= acc;
              at_path_start <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // one item at a time: busy right after taking one
  `WOA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input taken while an item is in flight")

  // finishing a path clears the running length and rearms the start point
  `WOA_ASSERT_NXT(a_path_rearm, (state == S_FINISH) && out_load && item.last_point,
    at_path_start && (length_acc == '0), "path end did not clear length state")

  // a partial length on the output matches the carried length
  `WOA_ASSERT_IMP(a_partial_len, out_valid && !out_data.length_final,
    (length_acc == out_data.path_length) && !at_path_start,
    "partial path length out of step with carried length")

endmodule

`default_nettype wire

// File: bench/tb_woa_waypoint_update_and_path_length.sv
// self-checking testbench for the waypoint update and path length block
`timescale 1ns / 1ps

module tb_woa_waypoint_update_and_path_length;
  import woa_pkg::*;

  // longer than the worst case for a last item, so this clears any result in flight
  localparam int QUIET_CYCLES = 70;
  // watchdog limit on the cycles of the whole run
  localparam int unsigned CYCLE_LIMIT = 2000000;
  // one long corner-to-corner path for a large running length
  localparam int LONG_ITEMS = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 40;
  localparam longint C_MIN = -524288;
  localparam longint C_MAX = 524287;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  woa_waypoint_update_and_path_length u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idling knobs, changed by the test tasks between phases
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_output = 1'b0;

  int fail_count = 0;
  int items_sent = 0;
  int paths_done = 0;
  int reg_writes = 0;
  int unsigned cycle_count = 0;

  // results still owed by the block, oldest first
  out_t expected_waypoints[$];
  out_t oldest_waypoint;

  // mirror of the register file, held at the reset values until written
  logic map_spiral = 1'b0;
  logic signed [GainWidth-1:0] map_gain_a = '0;
  logic [GainCWidth-1:0] map_gain_c = 13'd4096;
  logic signed [GainWidth-1:0] map_spiral_k = 16'sd4096;
  logic [PackWidth-1:0] map_low = '0;
  logic [PackWidth-1:0] map_high = '0;
  logic [PackWidth-1:0] map_start = '0;
  logic [PackWidth-1:0] map_goal = '0;

  // path state as the block should hold it
  longint track_prev_x = 0;
  longint track_prev_y = 0;
  logic [63:0] track_length = '0;
  logic track_at_start = 1'b1;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic longint sx20(input logic [CoordWidth-1:0] v);
    logic signed [CoordWidth-1:0] t;
    t = v;
    return t;
  endfunction

  // gain product back to coordinate scale, round half up
  function automatic longint round_q12(input longint p);
    longint q;
    q = p + 2048;
    return q >>> GainFrac;
  endfunction

  function automatic longint move_coord(input longint cur, input longint lead);
    longint d;
    if (map_spiral) begin
      d = lead - cur;
      if (d < 0) d = -d;
      return lead + round_q12(longint'(map_spiral_k) * d);
    end
    // circular: the distance is taken to the scaled leader, then pulled by A
    d = round_q12(longint'(map_gain_c) * lead) - cur;
    if (d < 0) d = -d;
    return lead - round_q12(longint'(map_gain_a) * d);
  endfunction

  // plain compare order, so inverted bounds send anything not below min to max
  function automatic longint clamp_coord(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] probe;
    logic [63:0] rem;
    res = '0;
    rem = n;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // coordinates are 20 bits, so the sum of squares never leaves 64 bits
  function automatic logic [63:0] seg_length(input longint ax, input longint ay,
                                             input longint bx, input longint by);
    longint dx;
    longint dy;
    dx = ax - bx;
    dy = ay - by;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return root64(dx * dx + dy * dy);
  endfunction

  function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
  endfunction

  // expected result of one waypoint; advances the path state
  function automatic out_t predict_waypoint(input in_t wp);
    out_t res;
    longint ux, uy, nx, ny, ax, ay;
    longint lo_x, lo_y, hi_x, hi_y;
    logic [63:0] acc;
    lo_x = sx20(map_low[CoordWidth-1:0]);
    lo_y = sx20(map_low[PackWidth-1:CoordWidth]);
    hi_x = sx20(map_high[CoordWidth-1:0]);
    hi_y = sx20(map_high[PackWidth-1:CoordWidth]);
    ux = move_coord(sx20(wp.cur_x), sx20(wp.lead_x));
    uy = move_coord(sx20(wp.cur_y), sx20(wp.lead_y));
    nx = clamp_coord(ux, lo_x, hi_x);
    ny = clamp_coord(uy, lo_y, hi_y);
    // first segment of a path runs from the fixed start point
    if (track_at_start) begin
      ax = sx20(map_start[CoordWidth-1:0]);
      ay = sx20(map_start[PackWidth-1:CoordWidth]);
      acc = '0;
    end else begin
      ax = track_prev_x;
      ay = track_prev_y;
      acc = track_length;
    end
    acc = add_capped(acc, seg_length(ax, ay, nx, ny));
    if (wp.last_point)
      acc = add_capped(acc, seg_length(nx, ny, sx20(map_goal[CoordWidth-1:0]),
                                       sx20(map_goal[PackWidth-1:CoordWidth])));
    res.new_x = nx[CoordWidth-1:0];
    res.new_y = ny[CoordWidth-1:0];
    res.was_clamped = (ux < lo_x) || (ux > hi_x) || (uy < lo_y) || (uy > hi_y);
    res.path_length = acc[LenWidth-1:0];
    res.length_final = wp.last_point;
    // a finished path leaves the accumulator clear for the next one
    track_length = wp.last_point ? 64'd0 : acc;
    track_at_start = wp.last_point;
    track_prev_x = nx;
    track_prev_y = ny;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // valid stays up across back-to-back items, only dropped for an idle gap
  task automatic send_waypoint(input in_t wp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= wp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_waypoints = {expected_waypoints, predict_waypoint(wp)};
    items_sent++;
    if (wp.last_point) paths_done++;
  endtask

  task automatic send_point(input longint cx, input longint cy, input longint lx,
                            input longint ly, input logic last);
    in_t wp;
    wp.cur_x = cx[CoordWidth-1:0];
    wp.cur_y = cy[CoordWidth-1:0];
    wp.lead_x = lx[CoordWidth-1:0];
    wp.lead_y = ly[CoordWidth-1:0];
    wp.last_point = last;
    send_waypoint(wp);
  endtask

  // lets every owed result drain, then covers anything still in the pipe
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_waypoints.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [PackWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:   map_spiral = value[0];
      REG_GAIN_A: map_gain_a = value[GainWidth-1:0];
      REG_GAIN_C: map_gain_c = value[GainCWidth-1:0];
      REG_SPIRAL: map_spiral_k = value[GainWidth-1:0];
      REG_LOW:    map_low = value;
      REG_HIGH:   map_high = value;
      REG_START:  map_start = value;
      REG_GOAL:   map_goal = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic setup_map(input logic [PackWidth-1:0] mode, input logic [PackWidth-1:0] ga,
                           input logic [PackWidth-1:0] gc, input logic [PackWidth-1:0] k,
                           input logic [PackWidth-1:0] lo, input logic [PackWidth-1:0] hi,
                           input logic [PackWidth-1:0] st, input logic [PackWidth-1:0] gl);
    write_reg(REG_MODE, mode);
    write_reg(REG_GAIN_A, ga);
    write_reg(REG_GAIN_C, gc);
    write_reg(REG_SPIRAL, k);
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
    write_reg(REG_START, st);
    write_reg(REG_GOAL, gl);
  endtask

  function automatic logic [PackWidth-1:0] pack_xy(input longint x, input longint y);
    return {y[CoordWidth-1:0], x[CoordWidth-1:0]};
  endfunction

  function automatic logic [PackWidth-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PackWidth-1:0];
  endfunction

  // extremes, small values near the origin and the full range
  function automatic logic [CoordWidth-1:0] pick_coord();
    case ($urandom_range(9))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2, 3, 4: return CoordWidth'($urandom_range(4000)) - 20'd2000;
      default: return CoordWidth'($urandom);
    endcase
  endfunction

  function automatic logic [GainWidth-1:0] pick_gain();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return GainWidth'($urandom_range(8192)) - 16'd4096;
      default: return GainWidth'($urandom);
    endcase
  endfunction

  // random register set; spare high bits of the narrow registers carry noise
  task automatic random_map();
    logic [CoordWidth-1:0] ax, bx, ay, by;
    logic [PackWidth-1:0] ga, gc, k, lo, hi;
    ax = pick_coord();
    bx = pick_coord();
    ay = pick_coord();
    by = pick_coord();
    ga = rand40();
    ga[GainWidth-1:0] = pick_gain();
    k = rand40();
    k[GainWidth-1:0] = pick_gain();
    gc = rand40();
    case ($urandom_range(3))
      0: gc[GainCWidth-1:0] = '0;
      1: gc[GainCWidth-1:0] = '1;
      2: gc[GainCWidth-1:0] = 13'd4096;
      default: ;
    endcase
    case ($urandom_range(4))
      0: begin
        lo = pack_xy(C_MIN, C_MIN);
        hi = pack_xy(C_MAX, C_MAX);
      end
      // drawn as is, so about half of these come out inverted
      1: begin
        lo = {ay, ax};
        hi = {by, bx};
      end
      default: begin
        lo = {(sx20(ay) < sx20(by)) ? ay : by, (sx20(ax) < sx20(bx)) ? ax : bx};
        hi = {(sx20(ay) < sx20(by)) ? by : ay, (sx20(ax) < sx20(bx)) ? bx : ax};
      end
    endcase
    setup_map(rand40(), ga, gc, k, lo, hi, rand40(), rand40());
  endtask

  // receiver: random stalls, or held off completely for the pressure test
  always @(posedge clk) begin
    if (rst || hold_output) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void flag_field(input string field, input logic [PackWidth-1:0] want_v,
                                     input logic [PackWidth-1:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_waypoints.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, out_data);
      end else begin
        oldest_waypoint = expected_waypoints.pop_front();
        if (out_data.new_x !== oldest_waypoint.new_x)
          flag_field("new_x", PackWidth'(oldest_waypoint.new_x), PackWidth'(out_data.new_x));
        if (out_data.new_y !== oldest_waypoint.new_y)
          flag_field("new_y", PackWidth'(oldest_waypoint.new_y), PackWidth'(out_data.new_y));
        if (out_data.was_clamped !== oldest_waypoint.was_clamped)
          flag_field("was_clamped", PackWidth'(oldest_waypoint.was_clamped),
                     PackWidth'(out_data.was_clamped));
        if (out_data.path_length !== oldest_waypoint.path_length)
          flag_field("path_length", PackWidth'(oldest_waypoint.path_length),
                     PackWidth'(out_data.path_length));
        if (out_data.length_final !== oldest_waypoint.length_final)
          flag_field("length_final", PackWidth'(oldest_waypoint.length_final),
                     PackWidth'(out_data.length_final));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // no register written: A is 0 and both bounds sit at the origin
  task automatic test_reset_defaults();
    send_point(1000, -1000, 5000, -7000, 1'b0);
    send_point(0, 0, 0, 0, 1'b0);
    send_point(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1);
    wait_quiet();
  endtask

  task automatic test_directed_cases();
    // circular, gains at their positive extremes, full map
    setup_map(40'd0, 40'h7FFF, 40'h1FFF, 40'd4096, pack_xy(C_MIN, C_MIN),
              pack_xy(C_MAX, C_MAX), pack_xy(-300000, 250000), pack_xy(C_MAX, C_MIN));
    send_point(C_MAX, C_MIN, C_MIN, C_MAX, 1'b0);
    send_point(C_MIN, C_MAX, C_MAX, C_MIN, 1'b0);
    send_point(0, 0, 0, 0, 1'b1);
    wait_quiet();
    // most negative A, C of zero
    setup_map(40'd0, 40'h8000, 40'd0, 40'd4096, pack_xy(C_MIN, C_MIN),
              pack_xy(C_MAX, C_MAX), pack_xy(-300000, 250000), pack_xy(C_MAX, C_MIN));
    send_point(12345, -6789, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
    wait_quiet();
    // spiral with the largest and smallest factor
    write_reg(REG_MODE, 40'd1);
    write_reg(REG_SPIRAL, 40'h7FFF);
    send_point(C_MIN, C_MAX, C_MAX, C_MIN, 1'b0);
    send_point(100, -100, 50, 60, 1'b1);
    wait_quiet();
    write_reg(REG_SPIRAL, 40'h8000);
    send_point(C_MAX, C_MAX, C_MIN, C_MIN, 1'b0);
    send_point(-2560, 2560, 2560, -2560, 1'b1);
    wait_quiet();
    // circular with A of one half, C of one, a tight box around the origin
    setup_map(40'd0, 40'd2048, 40'd4096, 40'd4096, pack_xy(-25600, -25600),
              pack_xy(25600, 25600), pack_xy(0, 0), pack_xy(25600, 25600));
    send_point(1000, 2000, 3000, -4000, 1'b0);
    send_point(0, 0, 30000, -30000, 1'b0);
    send_point(-500, 700, 800, 900, 1'b1);
    wait_quiet();
    // inverted bounds: factor 0 puts the point on the leader, min 100 above max -100
    setup_map(40'd1, 40'd0, 40'd4096, 40'd0, pack_xy(100, 100), pack_xy(-100, -100),
              pack_xy(-50, 50), pack_xy(0, 0));
    send_point(7, 7, -200, 0, 1'b0);
    send_point(-7, -7, 200, -300, 1'b0);
    send_point(0, 0, 100, -100, 1'b1);
    wait_quiet();
  endtask

  // one long path corner to corner, so the running length grows large
  task automatic test_long_path();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    setup_map(40'd1, 40'd0, 40'd4096, 40'd0, pack_xy(C_MIN, C_MIN), pack_xy(C_MAX, C_MAX),
              pack_xy(C_MIN, C_MIN), pack_xy(C_MAX, C_MIN));
    for (int k = 0; k < LONG_ITEMS; k++) begin
      if (k % 2 == 0)
        send_point(sx20(pick_coord()), sx20(pick_coord()), C_MAX, C_MAX, k == LONG_ITEMS - 1);
      else
        send_point(sx20(pick_coord()), sx20(pick_coord()), C_MIN, C_MIN, k == LONG_ITEMS - 1);
    end
    wait_quiet();
  endtask

  // receiver blocked for a long stretch while items keep coming, so the block backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_map();
    fork
      begin
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output <= 1'b0;
      end
    join_none
    for (int k = 0; k < 10; k++)
      send_point(sx20(pick_coord()), sx20(pick_coord()), sx20(pick_coord()),
                 sx20(pick_coord()), k == 9);
    wait_quiet();
  endtask

  // well-formed paths of random length; the leader often sits near the agent
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int target;
    int len;
    longint cx, cy, lx, ly;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int round = 0; round < 3; round++) begin
      random_map();
      target = items_sent + n_items / 3;
      while (items_sent < target) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
        for (int k = 1; k <= len; k++) begin
          cx = sx20(pick_coord());
          cy = sx20(pick_coord());
          if ($urandom_range(3) == 0) begin
            lx = cx + $urandom_range(2000) - 1000;
            ly = cy + $urandom_range(2000) - 1000;
          end else begin
            lx = sx20(pick_coord());
            ly = sx20(pick_coord());
          end
          send_point(cx, cy, lx, ly, k == len);
        end
      end
      wait_quiet();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_cases();
    test_long_path();
    test_output_backpressure();
    run_random_phase(0, 0, 190);
    run_random_phase(74, 0, 190);
    run_random_phase(0, 74, 190);
    run_random_phase(13, 13, 190);
    wait_quiet();
    if (expected_waypoints.size() != 0) fail_count++;
    $display("ran %0d waypoints over %0d paths with %0d register writes", items_sent,
             paths_done, reg_writes);
    $display("both update modes, inverted and full bounds, a long path, stalls");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
